/* design/kpst_pkg.sv */
// Shared constants, types and helpers for the key pair set table.
`default_nettype none
package kpst_pkg;

  localparam int KEY_W        = 11;
  localparam int PAIR_W       = 2 * KEY_W;
  localparam int FUNC_W       = 2;
  localparam int TOTAL_W      = 7;
  localparam int CAPACITY_DEF = 64;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic               hit;
    logic               status;
    logic [TOTAL_W-1:0] total;
  } res_t;

  function automatic int addr_w(input int depth);
    addr_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

/* design/kpst_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module kpst_ram #(
  parameter int WIDTH = kpst_pkg::PAIR_W,
  parameter int DEPTH = kpst_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [kpst_pkg::addr_w(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic [kpst_pkg::addr_w(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/kpst_ctrl.sv */
// Scan, update and swap-remove sequencer around the pair store.
`default_nettype none
module kpst_ctrl #(
  parameter int CAPACITY = kpst_pkg::CAPACITY_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [kpst_pkg::FUNC_W-1:0]            in_func,
  input  wire logic [kpst_pkg::PAIR_W-1:0]            in_pair,
  output logic                                        res_valid,
  input  wire logic                                   res_ready,
  output kpst_pkg::res_t                              res,
  output logic                                        ram_we,
  output logic [kpst_pkg::addr_w(CAPACITY)-1:0]       ram_waddr,
  output logic [kpst_pkg::PAIR_W-1:0]                 ram_wdata,
  output logic [kpst_pkg::addr_w(CAPACITY)-1:0]       ram_raddr,
  input  wire logic [kpst_pkg::PAIR_W-1:0]            ram_rdata
);

  localparam int AW = kpst_pkg::addr_w(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_DECIDE  = 3'd2;
  localparam logic [2:0] ST_MOVE_RD = 3'd3;
  localparam logic [2:0] ST_MOVE_WR = 3'd4;
  localparam logic [2:0] ST_RESP    = 3'd5;

  logic [2:0]                    state;
  logic [kpst_pkg::FUNC_W-1:0]   op;
  logic [kpst_pkg::PAIR_W-1:0]   pair;
  logic [AW-1:0]                 ci;
  logic [AW-1:0]                 slot;
  logic                          found;
  logic                          status;
  logic [CW-1:0]                 count;
  logic [CW+kpst_pkg::TOTAL_W-1:0] count_ext;
  logic                          full;
  logic                          last;

  assign full      = (count == CW'(CAPACITY));
  assign last      = (CW'(ci) == count - CW'(1));
  assign count_ext = {{kpst_pkg::TOTAL_W{1'b0}}, count};

  assign in_ready   = (state == ST_IDLE);
  assign res_valid  = (state == ST_RESP);
  assign res.hit    = found;
  assign res.status = status;
  assign res.total  = count_ext[kpst_pkg::TOTAL_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(count);
    ram_wdata = pair;
    ram_raddr = '0;
    case (state)
      ST_SCAN:    ram_raddr = ci + AW'(1);
      ST_MOVE_RD: ram_raddr = AW'(count);
      ST_DECIDE: begin
        if (op == kpst_pkg::FUNC_ADD && !found && !full) begin
          ram_we = 1'b1;
        end
      end
      ST_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = slot;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      found  <= 1'b0;
      status <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op     <= in_func;
            pair   <= in_pair;
            ci     <= '0;
            found  <= 1'b0;
            status <= 1'b0;
            state  <= (count == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (ram_rdata == pair) begin
            found <= 1'b1;
            slot  <= ci;
            state <= ST_DECIDE;
          end else if (last) begin
            state <= ST_DECIDE;
          end else begin
            ci <= ci + AW'(1);
          end
        end
        ST_DECIDE: begin
          state <= ST_RESP;
          if (op == kpst_pkg::FUNC_ADD && !found) begin
            if (full) begin
              status <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
          end else if (op == kpst_pkg::FUNC_REMOVE && found) begin
            count <= count - CW'(1);
            state <= ST_MOVE_RD;
          end
        end
        ST_MOVE_RD: state <= ST_MOVE_WR;
        ST_MOVE_WR: state <= ST_RESP;
        ST_RESP: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/key_pair_set_table.sv */
// Top level of the key pair set table: stream ports, pair store and result register.
//
//  channel  dir  tdata fields (low bit up)                      transactions
//  s_axis   in   func[1:0] key_first[12:2] key_second[23:13]    one per operation
//  m_axis   out  hit[0] status[1] entry_total[8:2], 0 pad       one per operation
//
// m_tvalid rises after acceptance once the scan of k entries (1 to the entry count, none
// when empty), the decide state and the response state have passed; the next operation
// is accepted once the result has moved into the output register. A remove that hits
// adds the move of the last entry (read, then write). The scan reads one store entry per cycle.
// Reset empties the set at once; store contents stay undefined until written.
// A stalled result waits in the output register; the next operation is accepted then.
`default_nettype none
module key_pair_set_table #(
  parameter int CAPACITY = kpst_pkg::CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // func, key_first, key_second
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // hit, status, entry_total, zero pad
);

  localparam int AW = kpst_pkg::addr_w(CAPACITY);

  logic                        res_valid;
  logic                        res_ready;
  kpst_pkg::res_t              res;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [kpst_pkg::PAIR_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [kpst_pkg::PAIR_W-1:0] ram_rdata;

  kpst_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tdata[1:0]),
    .in_pair   ({s_tdata[12:2], s_tdata[23:13]}),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  kpst_ram #(.WIDTH(kpst_pkg::PAIR_W), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {7'b0, res.total, res.status, res.hit};
    end
  end

endmodule
`default_nettype wire
